/* rtl/kicker_pulse_controller_unit_defines.svh */
// ----------------------------------------------------------------------------
// Kicker pulse controller assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KICKER_PULSE_CONTROLLER_UNIT_DEFINES_SVH
`define KICKER_PULSE_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication
`define KPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/kpc_pkg.sv */
// ----------------------------------------------------------------------------
// Kicker pulse controller package
// Command codes, channel modes, register map, shared structs and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package kpc_pkg;

	localparam int unsigned CNT_W = 16;
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	localparam logic [CNT_W-1:0] PULSE_MAX = 16'hFFFF;

	localparam logic [CNT_W-1:0] LOCKOUT_TICKS_RST = 16'd500;
	localparam logic [CNT_W-1:0] DISCHARGE_TOP_RST = 16'd4000;
	localparam logic [CNT_W-1:0] DISCHARGE_HIGH_RST = 16'd100;

	typedef enum logic [2:0] {
		FUNC_FIRE,
		FUNC_ARM,
		FUNC_DISARM,
		FUNC_DISCHARGE,
		FUNC_SLOW_TICK,
		FUNC_FAST_TICK,
		FUNC_US_TICK,
		FUNC_STATUS
	} func_t;

	typedef enum logic [1:0] {
		REG_LOCKOUT_TICKS,
		REG_DISCHARGE_TOP,
		REG_DISCHARGE_HIGH
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_LOW,
		MODE_PULSE,
		MODE_PWM
	} mode_t;

	typedef struct packed {
		logic [CNT_W-1:0] lockout_ticks;
		logic [CNT_W-1:0] discharge_top;
		logic [CNT_W-1:0] discharge_high;
	} cfg_t;

	typedef struct packed {
		logic             fire;
		logic [CNT_W-1:0] fire_width;
		logic             pwm_start;
		logic             pwm_stop;
		logic             us_tick;
	} chan_ctl_t;

	typedef struct packed {
		logic kick_level;
		logic chip_level;
		logic fired_now;
		logic armed_now;
		logic lockout_busy;
		logic auto_fired_flag;
	} res_t;

	function automatic logic [CNT_W-1:0] clamp_width(input logic [31:0] w);
		logic [31:0] lim;
		lim = {16'd0, PULSE_MAX};
		return (w > lim) ? PULSE_MAX : w[CNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/kpc_ifs.sv */
// ----------------------------------------------------------------------------
// Kicker pulse controller channels
// Valid/ready request channel and result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface kpc_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic        device;
	logic [31:0] width;
	logic        discharge_on;
	logic        beam_broken;
	logic        charger_ready;

	modport source (
		output valid, func, device, width, discharge_on, beam_broken, charger_ready,
		input ready
	);
	modport sink (
		input valid, func, device, width, discharge_on, beam_broken, charger_ready,
		output ready
	);
endinterface

interface kpc_res_if;
	logic valid;
	logic ready;
	logic kick_level;
	logic chip_level;
	logic fired_now;
	logic armed_now;
	logic lockout_busy;
	logic auto_fired_flag;

	modport source (
		output valid, kick_level, chip_level, fired_now, armed_now, lockout_busy,
			auto_fired_flag,
		input ready
	);
	modport sink (
		input valid, kick_level, chip_level, fired_now, armed_now, lockout_busy,
			auto_fired_flag,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/kicker_pulse_controller_unit.sv */
// Kicker pulse controller: takes one request per clock on cmd while res is not
// stalled and returns one result per request on res, through the input register
// and then the result register; sustained rate is one request per cycle while res
// is not stalled, set by the single update pass between those two registers. Requests
// fire, arm and disarm auto-fire, start or stop discharge PWM, advance the
// lockout, fast and microsecond timebases, or read and clear the auto-fire flag.
// The user writes configuration over the APB port only while no request is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
// Kicker pulse controller top level
// Input register, control state update, two output channels, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "kicker_pulse_controller_unit_defines.svh"

module kicker_pulse_controller_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	kpc_cmd_if.sink                          cmd,
	kpc_res_if.source                        res,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [kpc_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [kpc_pkg::DATA_W-1:0]  pwdata,
	output logic      [kpc_pkg::DATA_W-1:0]  prdata,
	output logic                             pready
);

	kpc_pkg::cfg_t              cfg;

	logic                       valid_s1;
	kpc_pkg::func_t             func_s1;
	logic                       device_s1;
	logic [31:0]                width_s1;
	logic                       discharge_on_s1;
	logic                       beam_s1;
	logic                       charger_s1;

	logic                       valid_s2;
	kpc_pkg::res_t              res_s2;

	logic                       arm_flag_q;
	logic                       arm_device_q;
	logic [kpc_pkg::CNT_W-1:0]  arm_width_q;
	logic                       fired_sticky_q;
	logic                       lockout_flag_q;
	logic [kpc_pkg::CNT_W-1:0]  lockout_count_q;

	logic                       adv;
	logic                       in_take;
	logic                       fire_cmd;
	logic                       auto_go;
	logic                       fire_go;
	logic                       fire_dev;
	logic [kpc_pkg::CNT_W-1:0]  fire_w;
	logic                       pwm_start;
	logic                       pwm_stop;
	logic                       us_tick;
	logic                       slow_tick;
	logic                       status_rd;
	kpc_pkg::chan_ctl_t         ctl0;
	kpc_pkg::chan_ctl_t         ctl1;
	logic                       kick_next;
	logic                       chip_next;
	kpc_pkg::res_t              res_d;

	kpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake
	assign adv = valid_s1 && (!valid_s2 || res.ready);
	assign cmd.ready = !valid_s1 || adv;
	assign in_take = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			func_s1 <= kpc_pkg::func_t'(cmd.func);
			device_s1 <= cmd.device;
			width_s1 <= cmd.width;
			discharge_on_s1 <= cmd.discharge_on;
			beam_s1 <= cmd.beam_broken;
			charger_s1 <= cmd.charger_ready;
		end
	end

	// decode
	assign fire_cmd = (func_s1 == kpc_pkg::FUNC_FIRE) && !lockout_flag_q;
	assign auto_go = (func_s1 == kpc_pkg::FUNC_FAST_TICK) && arm_flag_q && beam_s1
		&& charger_s1 && !lockout_flag_q;
	assign fire_go = fire_cmd || auto_go;
	assign fire_dev = fire_cmd ? device_s1 : arm_device_q;
	assign fire_w = fire_cmd ? kpc_pkg::clamp_width(width_s1) : arm_width_q;
	assign pwm_start = (func_s1 == kpc_pkg::FUNC_DISCHARGE) && discharge_on_s1;
	assign pwm_stop = (func_s1 == kpc_pkg::FUNC_DISCHARGE) && !discharge_on_s1;
	assign us_tick = (func_s1 == kpc_pkg::FUNC_US_TICK);
	assign slow_tick = (func_s1 == kpc_pkg::FUNC_SLOW_TICK);
	assign status_rd = (func_s1 == kpc_pkg::FUNC_STATUS);

	assign ctl0 = '{fire: fire_go && !fire_dev, fire_width: fire_w, pwm_start: pwm_start,
		pwm_stop: pwm_stop, us_tick: us_tick};
	assign ctl1 = '{fire: fire_go && fire_dev, fire_width: fire_w, pwm_start: pwm_start,
		pwm_stop: pwm_stop, us_tick: us_tick};

	kpc_channel u_kick (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.ctl        (ctl0),
		.pwm_top    (cfg.discharge_top),
		.pwm_high   (cfg.discharge_high),
		.level_next (kick_next)
	);

	kpc_channel u_chip (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.ctl        (ctl1),
		.pwm_top    (cfg.discharge_top),
		.pwm_high   (cfg.discharge_high),
		.level_next (chip_next)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_flag_q <= 1'b0;
			arm_device_q <= 1'b0;
			arm_width_q <= '0;
			fired_sticky_q <= 1'b0;
			lockout_flag_q <= 1'b0;
			lockout_count_q <= '0;
		end else if (adv) begin
			if (func_s1 == kpc_pkg::FUNC_ARM) begin
				arm_device_q <= device_s1;
				arm_width_q <= kpc_pkg::clamp_width(width_s1);
				arm_flag_q <= 1'b1;
			end else if (func_s1 == kpc_pkg::FUNC_DISARM || auto_go) begin
				arm_flag_q <= 1'b0;
			end
			if (auto_go) begin
				fired_sticky_q <= 1'b1;
			end else if (status_rd) begin
				fired_sticky_q <= 1'b0;
			end
			if (fire_go) begin
				lockout_count_q <= cfg.lockout_ticks;
				lockout_flag_q <= 1'b1;
			end else if (slow_tick && lockout_flag_q) begin
				if (lockout_count_q <= 16'd1) begin
					lockout_count_q <= '0;
					lockout_flag_q <= 1'b0;
				end else begin
					lockout_count_q <= lockout_count_q - 16'd1;
				end
			end
		end
	end

	// result
	always_comb begin
		res_d.kick_level = kick_next;
		res_d.chip_level = chip_next;
		res_d.fired_now = fire_go || pwm_start;
		if (func_s1 == kpc_pkg::FUNC_ARM) begin
			res_d.armed_now = 1'b1;
		end else if (func_s1 == kpc_pkg::FUNC_DISARM || auto_go) begin
			res_d.armed_now = 1'b0;
		end else begin
			res_d.armed_now = arm_flag_q;
		end
		if (fire_go) begin
			res_d.lockout_busy = 1'b1;
		end else if (slow_tick && lockout_flag_q) begin
			res_d.lockout_busy = (lockout_count_q > 16'd1);
		end else begin
			res_d.lockout_busy = lockout_flag_q;
		end
		res_d.auto_fired_flag = status_rd && fired_sticky_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_d;
		end
	end

	assign res.valid = valid_s2;
	assign res.kick_level = res_s2.kick_level;
	assign res.chip_level = res_s2.chip_level;
	assign res.fired_now = res_s2.fired_now;
	assign res.armed_now = res_s2.armed_now;
	assign res.lockout_busy = res_s2.lockout_busy;
	assign res.auto_fired_flag = res_s2.auto_fired_flag;

	`KPC_ASSERT_NEXT(a_fire_sets_lockout, adv && fire_go, valid_s2 && res.lockout_busy && lockout_flag_q, "fire did not set lockout")
	`KPC_ASSERT_NEXT(a_auto_disarms, adv && auto_go, !arm_flag_q && fired_sticky_q && !res.armed_now, "auto-fire did not disarm")
	`KPC_ASSERT_NEXT(a_flag_only_on_status, adv && !status_rd, !res.auto_fired_flag, "auto-fired flag outside status read")
	`KPC_ASSERT_NEXT(a_stall_holds_s1, valid_s1 && !adv, valid_s1 && $stable(func_s1) && $stable(width_s1), "stalled request changed")
	`KPC_ASSERT_NOW(a_no_fire_in_lockout, lockout_flag_q && valid_s1, !fire_go, "fire accepted during lockout")

endmodule

`default_nettype wire

/* rtl/kpc_regs.sv */
// ----------------------------------------------------------------------------
// Kicker pulse controller registers
// APB-style configuration registers: lockout length and discharge PWM.
// ----------------------------------------------------------------------------
`default_nettype none

module kpc_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [kpc_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [kpc_pkg::DATA_W-1:0]   pwdata,
	output logic      [kpc_pkg::DATA_W-1:0]   prdata,
	output logic                              pready,
	output kpc_pkg::cfg_t                     cfg
);

	kpc_pkg::cfg_t    cfg_q;
	kpc_pkg::reg_idx_t idx;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign idx = kpc_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lockout_ticks <= kpc_pkg::LOCKOUT_TICKS_RST;
			cfg_q.discharge_top <= kpc_pkg::DISCHARGE_TOP_RST;
			cfg_q.discharge_high <= kpc_pkg::DISCHARGE_HIGH_RST;
		end else if (wr_en) begin
			case (idx)
				kpc_pkg::REG_LOCKOUT_TICKS: cfg_q.lockout_ticks <= pwdata[15:0];
				kpc_pkg::REG_DISCHARGE_TOP: cfg_q.discharge_top <= pwdata[15:0];
				kpc_pkg::REG_DISCHARGE_HIGH: cfg_q.discharge_high <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			kpc_pkg::REG_LOCKOUT_TICKS: prdata = {16'd0, cfg_q.lockout_ticks};
			kpc_pkg::REG_DISCHARGE_TOP: prdata = {16'd0, cfg_q.discharge_top};
			kpc_pkg::REG_DISCHARGE_HIGH: prdata = {16'd0, cfg_q.discharge_high};
			default: prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/kpc_channel.sv */
// ----------------------------------------------------------------------------
// Kicker pulse controller output channel
// One solenoid channel: forced low, timed pulse, or discharge PWM.
// ----------------------------------------------------------------------------
`default_nettype none

module kpc_channel (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        adv,
	input  wire kpc_pkg::chan_ctl_t          ctl,
	input  wire logic [kpc_pkg::CNT_W-1:0]   pwm_top,
	input  wire logic [kpc_pkg::CNT_W-1:0]   pwm_high,
	output logic                             level_next
);

	kpc_pkg::mode_t              mode_q;
	kpc_pkg::mode_t              mode_d;
	logic [kpc_pkg::CNT_W-1:0]   count_q;
	logic [kpc_pkg::CNT_W-1:0]   count_d;
	logic [kpc_pkg::CNT_W-1:0]   limit_q;
	logic [kpc_pkg::CNT_W-1:0]   limit_d;
	logic [kpc_pkg::CNT_W-1:0]   cnt_inc;

	assign cnt_inc = count_q + 16'd1;

	always_comb begin
		mode_d = mode_q;
		count_d = count_q;
		limit_d = limit_q;
		if (ctl.fire) begin
			count_d = '0;
			limit_d = ctl.fire_width;
			mode_d = (ctl.fire_width != '0) ? kpc_pkg::MODE_PULSE : kpc_pkg::MODE_LOW;
		end else if (ctl.pwm_start) begin
			count_d = '0;
			limit_d = pwm_top;
			mode_d = kpc_pkg::MODE_PWM;
		end else if (ctl.pwm_stop) begin
			if (mode_q == kpc_pkg::MODE_PWM) begin
				mode_d = kpc_pkg::MODE_LOW;
			end
		end else if (ctl.us_tick) begin
			case (mode_q)
				kpc_pkg::MODE_PULSE: begin
					count_d = cnt_inc;
					if (cnt_inc >= limit_q) begin
						mode_d = kpc_pkg::MODE_LOW;
					end
				end
				kpc_pkg::MODE_PWM: begin
					count_d = (count_q >= limit_q) ? '0 : cnt_inc;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (mode_d)
			kpc_pkg::MODE_PULSE: level_next = 1'b1;
			kpc_pkg::MODE_PWM: level_next = (count_d < pwm_high);
			default: level_next = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= kpc_pkg::MODE_LOW;
			count_q <= '0;
			limit_q <= '0;
		end else if (adv) begin
			mode_q <= mode_d;
			count_q <= count_d;
			limit_q <= limit_d;
		end
	end

endmodule

`default_nettype wire
